FILE: sv/spa_pkg.sv
// Shared types, constants and state encodings for the sparse polynomial adder.
`timescale 1ns / 1ps

package spa_pkg;

    localparam int MAX_TERMS = 32;
    localparam int ADDR_W    = $clog2(MAX_TERMS);
    localparam int CNT_W     = $clog2(MAX_TERMS + 1);

    typedef struct packed {
        logic signed [15:0] expo;
        logic signed [15:0] coef;
    } term_t;

    typedef struct packed {
        logic signed [16:0] sum_coef;
        logic signed [15:0] sum_exponent;
        logic               empty_res;
        logic               overflowed;
        logic               final_term;
    } result_t;

    typedef struct packed {
        logic              wr_en;
        term_t             wr_term;
        logic              sort_start;
        logic              clear;
        logic [ADDR_W-1:0] rd_addr;
    } store_req_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             sort_done;
        term_t            rd_term;
    } store_rsp_t;

    typedef enum logic [1:0] {
        T_LOAD,
        T_SORT,
        T_MERGE
    } top_state_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDI,
        S_LDI,
        S_SCAN,
        S_WRI,
        S_DONE
    } sort_state_t;

    typedef enum logic [1:0] {
        M_IDLE,
        M_FETCH,
        M_EVAL,
        M_FLUSH
    } merge_state_t;

endpackage

FILE: sv/spa_if.sv
// Handshake channels for input terms and result terms.
`timescale 1ns / 1ps

interface spa_term_if;
    logic               valid;
    logic               ready;
    logic               poly_b;
    logic signed [15:0] coef;
    logic signed [15:0] exponent;
    logic               last;

    modport source (output valid, poly_b, coef, exponent, last, input ready);
    modport sink   (input valid, poly_b, coef, exponent, last, output ready);
endinterface

interface spa_result_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] sum_coef;
    logic signed [15:0] sum_exponent;
    logic               empty_res;
    logic               overflowed;
    logic               final_term;

    modport source (output valid, sum_coef, sum_exponent, empty_res, overflowed, final_term,
                    input ready);
    modport sink   (input valid, sum_coef, sum_exponent, empty_res, overflowed, final_term,
                    output ready);
endinterface

FILE: sv/spa_store.sv
// Term store: one synchronous memory, its fill count and an in-place exchange sort sequencer.
`timescale 1ns / 1ps

module spa_store
    import spa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  store_req_t req,
    output store_rsp_t rsp
);

    term_t             mem [MAX_TERMS];
    term_t             rd_data_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  i_reg;
    logic [CNT_W-1:0]  j_reg;
    term_t             cur_reg;
    sort_state_t       state_reg;
    sort_state_t       state_next;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    term_t             wdata;
    logic [ADDR_W-1:0] raddr;
    logic              swap;
    logic [CNT_W-1:0]  i_inc;
    logic [CNT_W-1:0]  i_inc2;
    logic [CNT_W-1:0]  j_inc;

    assign i_inc  = CNT_W'(i_reg + 1'b1);
    assign i_inc2 = CNT_W'(i_reg + 2'd2);
    assign j_inc  = CNT_W'(j_reg + 1'b1);

    // The held term sits at position i; a later term with a smaller exponent takes its place.
    assign swap = $signed(cur_reg.expo) > $signed(rd_data_reg.expo);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.sort_start)
                begin
                    state_next = (count_reg <= CNT_W'(1)) ? S_DONE : S_RDI;
                end
            end
            S_RDI:  state_next = S_LDI;
            S_LDI:  state_next = S_SCAN;
            S_SCAN:
            begin
                if (!(j_inc < count_reg))
                begin
                    state_next = S_WRI;
                end
            end
            S_WRI:  state_next = (i_inc2 < count_reg) ? S_RDI : S_DONE;
            S_DONE: state_next = S_DONE;
            default: state_next = S_IDLE;
        endcase
        if (req.clear)
        begin
            state_next = S_IDLE;
        end
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = count_reg[ADDR_W-1:0];
        wdata = req.wr_term;
        raddr = req.rd_addr;
        case (state_reg)
            S_IDLE:
            begin
                we = req.wr_en;
            end
            S_RDI:
            begin
                raddr = i_reg[ADDR_W-1:0];
            end
            S_LDI:
            begin
                raddr = i_inc[ADDR_W-1:0];
            end
            S_SCAN:
            begin
                raddr = j_inc[ADDR_W-1:0];
                we    = swap;
                waddr = j_reg[ADDR_W-1:0];
                wdata = cur_reg;
            end
            S_WRI:
            begin
                we    = 1'b1;
                waddr = i_reg[ADDR_W-1:0];
                wdata = cur_reg;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                i_reg <= '0;
            end
            S_LDI:
            begin
                cur_reg <= rd_data_reg;
                j_reg   <= i_inc;
            end
            S_SCAN:
            begin
                if (swap)
                begin
                    cur_reg <= rd_data_reg;
                end
                j_reg <= j_inc;
            end
            S_WRI:
            begin
                i_reg <= i_inc;
            end
            default:
            begin
                j_reg <= j_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (req.clear)
            begin
                count_reg <= '0;
            end
            else if (state_reg == S_IDLE && req.wr_en)
            begin
                count_reg <= CNT_W'(count_reg + 1'b1);
            end
        end
    end

    assign rsp.count     = count_reg;
    assign rsp.sort_done = (state_reg == S_DONE);
    assign rsp.rd_term   = rd_data_reg;

endmodule

FILE: sv/spa_merge.sv
// Merge walker: reads both sorted stores in step and feeds the result register.
`timescale 1ns / 1ps

module spa_merge
    import spa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                drop_flag,
    input  store_rsp_t          a_rsp,
    input  store_rsp_t          b_rsp,
    output logic [ADDR_W-1:0]   a_addr,
    output logic [ADDR_W-1:0]   b_addr,
    output logic                done,
    spa_result_if.source        result_out
);

    merge_state_t     state_reg;
    merge_state_t     state_next;
    logic [CNT_W-1:0] ia_reg;
    logic [CNT_W-1:0] ib_reg;
    result_t          hold_reg;
    logic             hold_valid_reg;
    result_t          out_reg;
    logic             out_valid_reg;

    logic               a_more;
    logic               b_more;
    logic               take_a;
    logic               take_b;
    logic               take_both;
    logic signed [16:0] coef_a;
    logic signed [16:0] coef_b;
    logic signed [16:0] coef_new;
    logic               emit;
    logic               out_free;
    logic               step;
    logic               flush;
    result_t            new_item;
    result_t            empty_item;
    result_t            last_item;

    assign a_more    = ia_reg < a_rsp.count;
    assign b_more    = ib_reg < b_rsp.count;
    assign take_both = a_more && b_more && (a_rsp.rd_term.expo == b_rsp.rd_term.expo);
    assign take_a    = a_more &&
                       (!b_more || $signed(a_rsp.rd_term.expo) < $signed(b_rsp.rd_term.expo));
    assign take_b    = b_more &&
                       (!a_more || $signed(b_rsp.rd_term.expo) < $signed(a_rsp.rd_term.expo));

    assign coef_a = 17'($signed(a_rsp.rd_term.coef));
    assign coef_b = 17'($signed(b_rsp.rd_term.coef));

    always_comb
    begin
        if (take_both)
        begin
            coef_new = coef_a + coef_b;
        end
        else if (take_a)
        begin
            coef_new = coef_a;
        end
        else
        begin
            coef_new = coef_b;
        end
    end

    // Equal exponents whose coefficients cancel leave no term behind.
    assign emit = take_a || take_b || (take_both && coef_new != '0);

    assign new_item.sum_coef     = coef_new;
    assign new_item.sum_exponent = take_b ? b_rsp.rd_term.expo : a_rsp.rd_term.expo;
    assign new_item.empty_res    = 1'b0;
    assign new_item.overflowed   = drop_flag;
    assign new_item.final_term   = 1'b0;

    assign empty_item.sum_coef     = '0;
    assign empty_item.sum_exponent = '0;
    assign empty_item.empty_res    = 1'b1;
    assign empty_item.overflowed   = drop_flag;
    assign empty_item.final_term   = 1'b1;

    always_comb
    begin
        last_item            = hold_reg;
        last_item.final_term = 1'b1;
    end

    assign out_free = !out_valid_reg || result_out.ready;
    assign step     = (state_reg == M_EVAL) && (a_more || b_more) && out_free;
    assign flush    = (state_reg == M_FLUSH) && out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    state_next = M_FETCH;
                end
            end
            M_FETCH: state_next = M_EVAL;
            M_EVAL:
            begin
                if (!a_more && !b_more)
                begin
                    state_next = M_FLUSH;
                end
                else if (out_free)
                begin
                    state_next = M_FETCH;
                end
            end
            M_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = M_IDLE;
                end
            end
            default: state_next = M_IDLE;
        endcase
    end

    always_comb
    begin
        done   = flush;
        a_addr = ia_reg[ADDR_W-1:0];
        b_addr = ib_reg[ADDR_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == M_IDLE)
        begin
            ia_reg <= '0;
            ib_reg <= '0;
        end
        else if (step)
        begin
            if (take_a || take_both)
            begin
                ia_reg <= CNT_W'(ia_reg + 1'b1);
            end
            if (take_b || take_both)
            begin
                ib_reg <= CNT_W'(ib_reg + 1'b1);
            end
        end
        if (step && emit)
        begin
            hold_reg <= new_item;
        end
        if (step && emit && hold_valid_reg)
        begin
            out_reg <= hold_reg;
        end
        else if (flush)
        begin
            if (hold_valid_reg)
            begin
                out_reg <= last_item;
            end
            else
            begin
                out_reg <= empty_item;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= M_IDLE;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (step && emit)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (flush)
            begin
                hold_valid_reg <= 1'b0;
            end
            if ((step && emit && hold_valid_reg) || flush)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.sum_coef     = out_reg.sum_coef;
    assign result_out.sum_exponent = out_reg.sum_exponent;
    assign result_out.empty_res    = out_reg.empty_res;
    assign result_out.overflowed   = out_reg.overflowed;
    assign result_out.final_term   = out_reg.final_term;

endmodule

FILE: sv/sparse_polynomial_add_top.sv
// Sparse polynomial adder: load sequencing, run control and the two term stores.
//
// Terms arrive on term_in, one beat each: poly_b picks store A or B, a zero coefficient
// stores nothing, and a store that already holds 32 terms drops the term and sets the
// overflow mark for the run. term_in stays ready throughout loading.
// The beat with last set starts the run: both stores are sorted by exponent in place, in
// parallel, each reading and writing its own memory one entry per cycle; term_in is held
// not ready until the run is over. The merge then walks both stores in step, through its
// fetch and evaluate states for each step, and results leave on result_out in ascending
// exponent order, the last beat marked final_term, or a single beat marked empty_res when
// nothing remains.
// A result register and a one-term hold stage sit before result_out; a stalled receiver
// simply pauses the merge. Once the final beat is in the result register, counts and the
// overflow mark clear and term_in is ready again, even while that beat waits.
// Reset clears the counts, the overflow mark and all sequencers; the store contents are
// left as they are, and only entries written in the current run are ever read.
`timescale 1ns / 1ps

module sparse_polynomial_add_top
    import spa_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    spa_term_if.sink      term_in,
    spa_result_if.source  result_out
);

    top_state_t  state_reg;
    top_state_t  state_next;
    logic        drop_flag_reg;

    store_req_t        a_req;
    store_req_t        b_req;
    store_rsp_t        a_rsp;
    store_rsp_t        b_rsp;
    logic [ADDR_W-1:0] a_addr;
    logic [ADDR_W-1:0] b_addr;
    logic              merge_start;
    logic              merge_done;
    logic              accept;
    logic              nonzero;
    logic              a_full;
    logic              b_full;
    logic              sort_start;
    term_t             in_term;

    assign accept  = term_in.valid && term_in.ready;
    assign nonzero = term_in.coef != '0;
    assign a_full  = a_rsp.count == CNT_W'(MAX_TERMS);
    assign b_full  = b_rsp.count == CNT_W'(MAX_TERMS);

    assign in_term.expo = term_in.exponent;
    assign in_term.coef = term_in.coef;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            T_LOAD:
            begin
                if (accept && term_in.last)
                begin
                    state_next = T_SORT;
                end
            end
            T_SORT:
            begin
                if (a_rsp.sort_done && b_rsp.sort_done)
                begin
                    state_next = T_MERGE;
                end
            end
            T_MERGE:
            begin
                if (merge_done)
                begin
                    state_next = T_LOAD;
                end
            end
            default: state_next = T_LOAD;
        endcase
    end

    always_comb
    begin
        term_in.ready = 1'b0;
        sort_start    = 1'b0;
        merge_start   = 1'b0;
        case (state_reg)
            T_LOAD:  term_in.ready = 1'b1;
            T_SORT:  sort_start    = 1'b1;
            T_MERGE: merge_start   = 1'b1;
            default: term_in.ready = 1'b0;
        endcase
    end

    always_comb
    begin
        a_req.wr_en      = accept && nonzero && !term_in.poly_b && !a_full;
        a_req.wr_term    = in_term;
        a_req.sort_start = sort_start;
        a_req.clear      = merge_done;
        a_req.rd_addr    = a_addr;
        b_req.wr_en      = accept && nonzero && term_in.poly_b && !b_full;
        b_req.wr_term    = in_term;
        b_req.sort_start = sort_start;
        b_req.clear      = merge_done;
        b_req.rd_addr    = b_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_LOAD;
            drop_flag_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (merge_done)
            begin
                drop_flag_reg <= 1'b0;
            end
            else if (accept && nonzero && (term_in.poly_b ? b_full : a_full))
            begin
                drop_flag_reg <= 1'b1;
            end
        end
    end

    spa_store u_store_a (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (a_req),
        .rsp   (a_rsp)
    );

    spa_store u_store_b (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (b_req),
        .rsp   (b_rsp)
    );

    spa_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (merge_start),
        .drop_flag  (drop_flag_reg),
        .a_rsp      (a_rsp),
        .b_rsp      (b_rsp),
        .a_addr     (a_addr),
        .b_addr     (b_addr),
        .done       (merge_done),
        .result_out (result_out)
    );

endmodule
